[rtl/rgpec_pkg.sv]
// ----------------------------------------------------------------------------
// rgpec_pkg
// Shared types, constants and CRC helpers for the register-group check block.
// ----------------------------------------------------------------------------
package rgpec_pkg;

    localparam int DEF_MAX_DEVICES = 16;
    localparam int DEF_GROUP_BYTES = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] CRC_POLY = 16'h4599;
    localparam logic [15:0] CRC_SEED = 16'd16;

    // One finished group, handed from the front to the back.
    typedef struct packed {
        logic [47:0] data;
        logic [15:0] calc;
        logic [15:0] recv;
        logic [3:0]  idx;
        logic        last;
    } t_grp_rec;

    // Entry of the 256-entry CRC table.
    function automatic logic [15:0] crc_rom(input logic [7:0] addr);
        logic [15:0] r;
        r = {1'b0, addr, 7'b0};
        for (int b = 0; b < 8; b++) begin
            if (r[14]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] din);
        return {rem[7:0], 8'h00} ^ crc_rom(rem[14:7] ^ din);
    endfunction

endpackage

[rtl/rgpec_front.sv]
// ----------------------------------------------------------------------------
// rgpec_front
// Byte framer: tracks position in the group, runs the CRC, collects data bytes
// and emits one record per completed group into the queue.
// ----------------------------------------------------------------------------
module rgpec_front #(
    parameter int MAX_DEVICES = rgpec_pkg::DEF_MAX_DEVICES,
    parameter int GROUP_BYTES = rgpec_pkg::DEF_GROUP_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    output logic                o_rec_push,
    output rgpec_pkg::t_grp_rec o_rec
);
    import rgpec_pkg::*;

    localparam int          EFF_MAX_I = (MAX_DEVICES < 16) ? MAX_DEVICES : 16;
    localparam logic [4:0]  EFF_MAX   = 5'(EFF_MAX_I);
    localparam logic [2:0]  GB        = 3'(GROUP_BYTES);

    logic [4:0]  r_dev_count;
    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_pos, n_pos;
    logic [3:0]  r_gc, n_gc;
    logic [7:0]  r_hi;
    logic [7:0]  r_data [GROUP_BYTES];

    logic [15:0] crc_e;
    logic [2:0]  pos_e;
    logic [3:0]  gc_e;
    logic [4:0]  eff_count;
    logic        last;
    logic [47:0] data_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count <= 5'd1;
            r_crc       <= CRC_SEED;
            r_pos       <= '0;
            r_gc        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dev_count <= i_cfg_data;
            end
            r_crc <= n_crc;
            r_pos <= n_pos;
            r_gc  <= n_gc;
        end
    end

    // A frame start restarts the group even in the middle of one.
    assign crc_e = i_frame_start ? CRC_SEED : r_crc;
    assign pos_e = i_frame_start ? 3'd0 : r_pos;
    assign gc_e  = i_frame_start ? 4'd0 : r_gc;

    always_comb begin
        eff_count = r_dev_count;
        if (eff_count == 5'd0) begin
            eff_count = 5'd1;
        end
        if (eff_count > EFF_MAX) begin
            eff_count = EFF_MAX;
        end
    end

    assign last = ({1'b0, gc_e} + 5'd1) >= eff_count;

    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos;
        n_gc       = r_gc;
        o_rec_push = 1'b0;
        if (i_accept) begin
            n_crc = crc_e;
            n_gc  = gc_e;
            if (pos_e < GB) begin
                n_crc = crc_byte(crc_e, i_rx_byte);
                n_pos = pos_e + 3'd1;
            end else if (pos_e == GB) begin
                n_pos = pos_e + 3'd1;
            end else begin
                o_rec_push = 1'b1;
                n_pos      = 3'd0;
                n_crc      = CRC_SEED;
                n_gc       = last ? 4'd0 : gc_e + 4'd1;
            end
        end
    end

    for (genvar k = 0; k < GROUP_BYTES; k++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (i_accept && pos_e == 3'(k)) begin
                r_data[k] <= i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && pos_e == GB) begin
            r_hi <= i_rx_byte;
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_data
        if (k < GROUP_BYTES) begin : g_have
            assign data_vec[8*k +: 8] = r_data[k];
        end else begin : g_none
            assign data_vec[8*k +: 8] = 8'h00;
        end
    end

    assign o_rec.data = data_vec;
    assign o_rec.calc = {r_crc[14:0], 1'b0};
    assign o_rec.recv = {r_hi, i_rx_byte};
    assign o_rec.idx  = r_gc;
    assign o_rec.last = last;

endmodule

[rtl/rgpec_queue.sv]
// ----------------------------------------------------------------------------
// rgpec_queue
// Short register queue of group records between the front and the back.
// ----------------------------------------------------------------------------
module rgpec_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgpec_pkg::t_grp_rec i_rec,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output rgpec_pkg::t_grp_rec o_rec
);
    import rgpec_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_grp_rec        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

[rtl/rgpec_back.sv]
// ----------------------------------------------------------------------------
// rgpec_back
// Compares check words, keeps the sticky frame error and holds the result
// register that the consumer pops.
// ----------------------------------------------------------------------------
module rgpec_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  rgpec_pkg::t_grp_rec i_rec,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [15:0]         o_value_first,
    output logic [15:0]         o_value_second,
    output logic [15:0]         o_value_third,
    output logic                o_check_ok,
    output logic [3:0]          o_group_index,
    output logic                o_last_group,
    output logic                o_frame_error
);
    import rgpec_pkg::*;

    logic r_valid;
    logic r_err;
    logic ok;
    logic err;

    assign o_empty = !r_valid;
    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);
    assign ok      = i_rec.calc == i_rec.recv;
    // Group zero always opens a fresh frame, so the sticky error restarts there.
    assign err     = !ok || (i_rec.idx != 4'd0 && r_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_valid <= 1'b1;
                r_err   <= err;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_value_first  <= i_rec.data[15:0];
            o_value_second <= i_rec.data[31:16];
            o_value_third  <= i_rec.data[47:32];
            o_check_ok     <= ok;
            o_group_index  <= i_rec.idx;
            o_last_group   <= i_rec.last;
            o_frame_error  <= err;
        end
    end

endmodule

[rtl/register_group_pec_checker_core.sv]
// ----------------------------------------------------------------------------
// register_group_pec_checker_core
// Checks the CRC-15 word of each 8-byte register group of a daisy-chain
// response and reports the decoded group values.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full; the CRC table lookup and XOR run in the front.
// A group result is written into the queue at the edge that accepts its second check byte
// and moves on into the output register once that register is empty or being popped.
// A two-entry queue and the output register let input and output stall apart.
// Reset is synchronous, active low: it clears the framing state and queue and
// sets the device count to one.
module register_group_pec_checker_core #(
    parameter int MAX_DEVICES = rgpec_pkg::DEF_MAX_DEVICES,
    parameter int GROUP_BYTES = rgpec_pkg::DEF_GROUP_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] o_value_first,
    output logic [15:0] o_value_second,
    output logic [15:0] o_value_third,
    output logic        o_check_ok,
    output logic [3:0]  o_group_index,
    output logic        o_last_group,
    output logic        o_frame_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import rgpec_pkg::*;

    t_grp_rec front_rec;
    t_grp_rec q_rec;
    logic     rec_push;
    logic     q_empty;
    logic     q_pop;
    logic     accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    rgpec_front #(
        .MAX_DEVICES (MAX_DEVICES),
        .GROUP_BYTES (GROUP_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_rec_push    (rec_push),
        .o_rec         (front_rec)
    );

    rgpec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (q_rec)
    );

    rgpec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_rec          (q_rec),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_value_first  (o_value_first),
        .o_value_second (o_value_second),
        .o_value_third  (o_value_third),
        .o_check_ok     (o_check_ok),
        .o_group_index  (o_group_index),
        .o_last_group   (o_last_group),
        .o_frame_error  (o_frame_error)
    );

endmodule
